// ----- design/mbet_pkg.sv -----
// mbet_pkg: shared types and constants of the mandelbrot escape-time block
// beat structs, configuration record, register indexes, adder op codes
// no dependencies
package mbet_pkg;

    // fixed-point format and frame size
    localparam int FRAC_BITS = 56;
    localparam int MAX_SIDE  = 4096;

    // signed 64-bit limits
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // iteration limit after reset
    localparam logic [15:0] LIMIT_RESET = 16'd4000;

    // multiplier: four 32x32 partial products
    localparam int MUL_PARTS = 4;
    localparam int PHASE_W   = $clog2(MUL_PARTS + 2);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_REAL_ORIGIN = 3'd0;
    localparam t_cfg_idx CFG_IMAG_TOP    = 3'd1;
    localparam t_cfg_idx CFG_REAL_STEP   = 3'd2;
    localparam t_cfg_idx CFG_IMAG_STEP   = 3'd3;
    localparam t_cfg_idx CFG_ITER_LIMIT  = 3'd4;

    // input beat
    typedef struct packed {
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
        logic        frame_start;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [15:0] escape_count;
        logic        in_set;
        logic [15:0] frame_max;
    } t_out_beat;

    // configuration record
    typedef struct packed {
        logic signed [63:0] real_origin;
        logic signed [63:0] imag_top;
        logic [62:0]        real_step;
        logic [62:0]        imag_step;
        logic [15:0]        iteration_limit;
    } t_cfg;

    // saturating adder operations
    typedef enum logic [1:0] {
        ALU_ADD      = 2'd0,
        ALU_SUB      = 2'd1,
        ALU_COORD_UP = 2'd2,
        ALU_COORD_DN = 2'd3
    } t_alu_op;

    // multiplier result: fixed-point product and half of the raw product
    typedef struct packed {
        logic [63:0] fx;
        logic [63:0] off;
        logic        off_ovf;
    } t_mul_res;

endpackage

// ----- design/mbet_mul.sv -----
// mbet_mul: shared 64x64 signed fixed-point multiplier, one 32x32 partial product a cycle
// result saturates to the signed 64-bit range; also gives the raw product halved
// depends on mbet_pkg
module mbet_mul #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output mbet_pkg::t_mul_res  o_res
);

    localparam logic [mbet_pkg::PHASE_W-1:0] LAST_PART =
        mbet_pkg::PHASE_W'(mbet_pkg::MUL_PARTS);
    localparam logic [mbet_pkg::PHASE_W-1:0] CONV_PHASE =
        mbet_pkg::PHASE_W'(mbet_pkg::MUL_PARTS + 1);

    logic [63:0]                  r_a_mag;
    logic [63:0]                  r_b_mag;
    logic                         r_neg;
    logic [127:0]                 r_acc;
    logic [127:0]                 r_pp_sh;
    logic [mbet_pkg::PHASE_W-1:0] r_phase;
    logic                         r_busy;
    logic                         r_done;
    mbet_pkg::t_mul_res           r_res;

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [31:0]  pp_a;
    logic [31:0]  pp_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         fx_ovf;
    logic [63:0]  fx_mag;
    logic [63:0]  fx_val;

    // operand magnitudes
    assign mag_a = i_a[63] ? (64'd0 - i_a) : i_a;
    assign mag_b = i_b[63] ? (64'd0 - i_b) : i_b;

    // partial product for the current phase
    always_comb begin
        pp_a = r_phase[1] ? r_a_mag[63:32] : r_a_mag[31:0];
        pp_b = r_phase[0] ? r_b_mag[63:32] : r_b_mag[31:0];
        pp   = 64'(pp_a) * 64'(pp_b);
        case (r_phase[1:0]) inside
            2'd0:          pp_sh = {64'd0, pp};
            2'd1, 2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default:       pp_sh = {pp, 64'd0};
        endcase
    end

    // drop fraction bits, apply sign, saturate
    always_comb begin
        fx_ovf = |(r_acc >> (64 + FRAC_BITS));
        fx_mag = r_acc[FRAC_BITS +: 64];
        if (fx_ovf) begin
            fx_val = r_neg ? mbet_pkg::SMIN : mbet_pkg::SMAX;
        end else if (!r_neg) begin
            fx_val = fx_mag[63] ? mbet_pkg::SMAX : fx_mag;
        end else begin
            fx_val = fx_mag[63] ? mbet_pkg::SMIN : (64'd0 - fx_mag);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (r_busy) begin
                if (r_phase == CONV_PHASE) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a_mag <= mag_a;
            r_b_mag <= mag_b;
            r_neg   <= i_a[63] ^ i_b[63];
            r_acc   <= '0;
        end else if (r_busy) begin
            r_pp_sh <= pp_sh;
            if (r_phase != '0 && r_phase <= LAST_PART) begin
                r_acc <= r_acc + r_pp_sh;
            end
            if (r_phase == CONV_PHASE) begin
                r_res.fx      <= fx_val;
                r_res.off     <= r_acc[64:1];
                r_res.off_ovf <= |r_acc[127:65];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- design/mbet_alu.sv -----
// mbet_alu: saturating 64-bit add/subtract and pixel-coordinate offset unit
// combinational, shared by every fixed-point sum and difference of the sequencer
// depends on mbet_pkg
module mbet_alu (
    input  mbet_pkg::t_alu_op i_op,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  logic              i_ovf,
    output logic [63:0]       o_y
);

    localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;

    logic [63:0] sum;
    logic [63:0] dif;
    logic [63:0] biased;
    logic [64:0] up;
    logic [64:0] dn;

    always_comb begin
        sum    = i_a + i_b;
        dif    = i_a - i_b;
        biased = i_a ^ MSB;
        up     = {1'b0, biased} + {1'b0, i_b};
        dn     = {1'b0, biased} - {1'b0, i_b};
        unique case (i_op)
            // signed sum, saturated
            mbet_pkg::ALU_ADD: begin
                if (i_a[63] == i_b[63] && sum[63] != i_a[63]) begin
                    o_y = i_a[63] ? mbet_pkg::SMIN : mbet_pkg::SMAX;
                end else begin
                    o_y = sum;
                end
            end
            // signed difference, saturated
            mbet_pkg::ALU_SUB: begin
                if (i_a[63] != i_b[63] && dif[63] != i_a[63]) begin
                    o_y = i_a[63] ? mbet_pkg::SMIN : mbet_pkg::SMAX;
                end else begin
                    o_y = dif;
                end
            end
            // base plus unsigned offset, in biased form
            mbet_pkg::ALU_COORD_UP: begin
                o_y = (i_ovf || up[64]) ? mbet_pkg::SMAX : (up[63:0] ^ MSB);
            end
            // base minus unsigned offset, in biased form
            mbet_pkg::ALU_COORD_DN: begin
                o_y = (i_ovf || dn[64]) ? mbet_pkg::SMIN : (dn[63:0] ^ MSB);
            end
            default: o_y = sum;
        endcase
    end

endmodule

// ----- design/mbet_seq.sv -----
// mbet_seq: sequencer that runs one pixel through the shared multiplier and adder
// pixel centre, cardioid and bulb test, escape loop, running maximum
// depends on mbet_pkg, mbet_mul, mbet_alu
module mbet_seq #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mbet_pkg::t_in_beat  i_in_data,
    output logic                o_idle,
    input  mbet_pkg::t_cfg      i_cfg,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output mbet_pkg::t_out_beat o_res
);

    localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] QUARTER   = 64'd1 << (FRAC_BITS - 2);
    localparam logic [63:0] SIXTEENTH = 64'd1 << (FRAC_BITS - 4);
    localparam logic [63:0] FOUR      = 64'd1 << (FRAC_BITS + 2);

    typedef enum logic [25:0] {
        S_IDLE = 26'h0000001,
        S_CXM  = 26'h0000002,
        S_CXA  = 26'h0000004,
        S_CYM  = 26'h0000008,
        S_CYA  = 26'h0000010,
        S_Y2   = 26'h0000020,
        S_XQ   = 26'h0000040,
        S_XQ2  = 26'h0000080,
        S_Q    = 26'h0000100,
        S_QX   = 26'h0000200,
        S_QM   = 26'h0000400,
        S_CARD = 26'h0000800,
        S_XP   = 26'h0001000,
        S_XPM  = 26'h0002000,
        S_BUL  = 26'h0004000,
        S_BCMP = 26'h0008000,
        S_MAG  = 26'h0010000,
        S_TEST = 26'h0020000,
        S_P    = 26'h0040000,
        S_P2   = 26'h0080000,
        S_ZY   = 26'h0100000,
        S_D    = 26'h0200000,
        S_ZX   = 26'h0400000,
        S_ZX2  = 26'h0800000,
        S_ZY2  = 26'h1000000,
        S_DONE = 26'h2000000
    } t_state;

    // saturate an index to the last row or column of the frame
    function automatic logic [11:0] clamp_idx(input logic [11:0] v);
        if (int'(v) > mbet_pkg::MAX_SIDE - 1) begin
            return 12'(mbet_pkg::MAX_SIDE - 1);
        end
        return v;
    endfunction

    t_state      r_state, n_state;
    logic        r_issued, n_issued;
    logic [11:0] r_row, n_row;
    logic [11:0] r_col, n_col;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [63:0] r_y2, n_y2;
    logic [63:0] r_xq, n_xq;
    logic [63:0] r_q, n_q;
    logic [63:0] r_t, n_t;
    logic        r_ovf, n_ovf;
    logic [63:0] r_zx, n_zx;
    logic [63:0] r_zy, n_zy;
    logic [63:0] r_zx2, n_zx2;
    logic [63:0] r_zy2, n_zy2;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_max, n_max;

    logic               mul_req;
    logic               mul_start;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic               mul_done;
    mbet_pkg::t_mul_res mul_res;
    mbet_pkg::t_alu_op  alu_op;
    logic [63:0]        alu_a;
    logic [63:0]        alu_b;
    logic               alu_ovf;
    logic [63:0]        alu_y;
    logic [15:0]        max_new;

    mbet_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    mbet_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_ovf (alu_ovf),
        .o_y   (alu_y)
    );

    // running maximum after this pixel
    assign max_new = (r_cnt < i_cfg.iteration_limit && r_cnt > r_max) ? r_cnt : r_max;

    // one multiply in flight per multiply state
    assign mul_start = mul_req && !r_issued;

    // result beat
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.escape_count = r_cnt;
    assign o_res.in_set       = (r_cnt == i_cfg.iteration_limit);
    assign o_res.frame_max    = max_new;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_x     = r_x;
        n_y     = r_y;
        n_y2    = r_y2;
        n_xq    = r_xq;
        n_q     = r_q;
        n_t     = r_t;
        n_ovf   = r_ovf;
        n_zx    = r_zx;
        n_zy    = r_zy;
        n_zx2   = r_zx2;
        n_zy2   = r_zy2;
        n_cnt   = r_cnt;
        n_max   = r_max;
        mul_req = 1'b0;
        mul_a   = r_t;
        mul_b   = r_t;
        alu_op  = mbet_pkg::ALU_ADD;
        alu_a   = r_t;
        alu_b   = r_t;
        alu_ovf = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_row = clamp_idx(i_in_data.pixel_row);
                    n_col = clamp_idx(i_in_data.pixel_column);
                    if (i_in_data.frame_start) begin
                        n_max = '0;
                    end
                    n_state = S_CXM;
                end
            end
            // column offset (2*col+1)*step/2
            S_CXM: begin
                mul_req = 1'b1;
                mul_a   = {51'd0, r_col, 1'b1};
                mul_b   = {1'b0, i_cfg.real_step};
                if (mul_done) begin
                    n_t     = mul_res.off;
                    n_ovf   = mul_res.off_ovf;
                    n_state = S_CXA;
                end
            end
            S_CXA: begin
                alu_op  = mbet_pkg::ALU_COORD_UP;
                alu_a   = i_cfg.real_origin;
                n_x     = alu_y;
                n_state = S_CYM;
            end
            // row offset, taken downward from the top edge
            S_CYM: begin
                mul_req = 1'b1;
                mul_a   = {51'd0, r_row, 1'b1};
                mul_b   = {1'b0, i_cfg.imag_step};
                if (mul_done) begin
                    n_t     = mul_res.off;
                    n_ovf   = mul_res.off_ovf;
                    n_state = S_CYA;
                end
            end
            S_CYA: begin
                alu_op  = mbet_pkg::ALU_COORD_DN;
                alu_a   = i_cfg.imag_top;
                n_y     = alu_y;
                n_state = S_Y2;
            end
            // main cardioid test
            S_Y2: begin
                mul_req = 1'b1;
                mul_a   = r_y;
                mul_b   = r_y;
                if (mul_done) begin
                    n_y2    = mul_res.fx;
                    n_state = S_XQ;
                end
            end
            S_XQ: begin
                alu_op  = mbet_pkg::ALU_SUB;
                alu_a   = r_x;
                alu_b   = QUARTER;
                n_xq    = alu_y;
                n_state = S_XQ2;
            end
            S_XQ2: begin
                mul_req = 1'b1;
                mul_a   = r_xq;
                mul_b   = r_xq;
                if (mul_done) begin
                    n_t     = mul_res.fx;
                    n_state = S_Q;
                end
            end
            S_Q: begin
                alu_b   = r_y2;
                n_q     = alu_y;
                n_state = S_QX;
            end
            S_QX: begin
                alu_a   = r_q;
                alu_b   = r_xq;
                n_t     = alu_y;
                n_state = S_QM;
            end
            S_QM: begin
                mul_req = 1'b1;
                mul_a   = r_q;
                mul_b   = r_t;
                if (mul_done) begin
                    n_t     = mul_res.fx;
                    n_state = S_CARD;
                end
            end
            S_CARD: begin
                if ($signed(r_t) <= $signed({2'b00, r_y2[63:2]})) begin
                    n_cnt   = i_cfg.iteration_limit;
                    n_state = S_DONE;
                end else begin
                    n_state = S_XP;
                end
            end
            // period-2 bulb test
            S_XP: begin
                alu_a   = r_x;
                alu_b   = ONE;
                n_t     = alu_y;
                n_state = S_XPM;
            end
            S_XPM: begin
                mul_req = 1'b1;
                if (mul_done) begin
                    n_t     = mul_res.fx;
                    n_state = S_BUL;
                end
            end
            S_BUL: begin
                alu_b   = r_y2;
                n_t     = alu_y;
                n_state = S_BCMP;
            end
            S_BCMP: begin
                if ($signed(r_t) <= $signed(SIXTEENTH)) begin
                    n_cnt   = i_cfg.iteration_limit;
                    n_state = S_DONE;
                end else begin
                    n_zx    = '0;
                    n_zy    = '0;
                    n_zx2   = '0;
                    n_zy2   = '0;
                    n_cnt   = '0;
                    n_state = S_MAG;
                end
            end
            // escape loop: |z|^2 check
            S_MAG: begin
                alu_a   = r_zx2;
                alu_b   = r_zy2;
                n_t     = alu_y;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_cnt < i_cfg.iteration_limit && $signed(r_t) <= $signed(FOUR)) begin
                    n_state = S_P;
                end else begin
                    n_state = S_DONE;
                end
            end
            // zy = 2*zx*zy + y
            S_P: begin
                mul_req = 1'b1;
                mul_a   = r_zx;
                mul_b   = r_zy;
                if (mul_done) begin
                    n_t     = mul_res.fx;
                    n_state = S_P2;
                end
            end
            S_P2: begin
                n_t     = alu_y;
                n_state = S_ZY;
            end
            S_ZY: begin
                alu_b   = r_y;
                n_zy    = alu_y;
                n_state = S_D;
            end
            // zx = zx^2 - zy^2 + x
            S_D: begin
                alu_op  = mbet_pkg::ALU_SUB;
                alu_a   = r_zx2;
                alu_b   = r_zy2;
                n_t     = alu_y;
                n_state = S_ZX;
            end
            S_ZX: begin
                alu_b   = r_x;
                n_zx    = alu_y;
                n_state = S_ZX2;
            end
            // new squares
            S_ZX2: begin
                mul_req = 1'b1;
                mul_a   = r_zx;
                mul_b   = r_zx;
                if (mul_done) begin
                    n_zx2   = mul_res.fx;
                    n_state = S_ZY2;
                end
            end
            S_ZY2: begin
                mul_req = 1'b1;
                mul_a   = r_zy;
                mul_b   = r_zy;
                if (mul_done) begin
                    n_zy2   = mul_res.fx;
                    n_cnt   = r_cnt + 16'd1;
                    n_state = S_MAG;
                end
            end
            // hand the result beat to the output register
            S_DONE: begin
                if (i_res_ready) begin
                    n_max   = max_new;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_issued = r_issued;
        if (mul_start) begin
            n_issued = 1'b1;
        end
        if (mul_done) begin
            n_issued = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_max    <= '0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_max    <= n_max;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_x   <= n_x;
        r_y   <= n_y;
        r_y2  <= n_y2;
        r_xq  <= n_xq;
        r_q   <= n_q;
        r_t   <= n_t;
        r_ovf <= n_ovf;
        r_zx  <= n_zx;
        r_zy  <= n_zy;
        r_zx2 <= n_zx2;
        r_zy2 <= n_zy2;
        r_cnt <= n_cnt;
    end

endmodule

// ----- design/mandelbrot_escape_time.sv -----
// mandelbrot_escape_time: top level, escape count of one pixel per input beat
// holds the configuration registers and the output register around the sequencer
// depends on mbet_pkg, mbet_seq
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//   out      from block o_out_valid / i_out_stall o_out_data (t_out_beat)
//   cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one pixel at a time; every product goes through one multiplier that takes
// four 32x32 partial products in turn; a point in the main cardioid or the
// period-2 bulb ends before the escape loop, and each loop iteration takes
// three products and six adder or compare steps
// reset is synchronous, active low, and restores the configuration defaults
// the output register lets the next pixel start while a result beat is stalled
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mbet_pkg::t_in_beat          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mbet_pkg::t_out_beat         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);

    mbet_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    mbet_pkg::t_out_beat r_out_data;

    logic                seq_idle;
    logic                res_valid;
    logic                res_ready;
    mbet_pkg::t_out_beat res;

    mbet_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_idle      (seq_idle),
        .i_cfg       (r_cfg),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !seq_idle;
    assign res_ready   = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin     <= '0;
            r_cfg.imag_top        <= '0;
            r_cfg.real_step       <= '0;
            r_cfg.imag_step       <= '0;
            r_cfg.iteration_limit <= mbet_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbet_pkg::CFG_REAL_ORIGIN: r_cfg.real_origin     <= i_cfg_data;
                mbet_pkg::CFG_IMAG_TOP:    r_cfg.imag_top        <= i_cfg_data;
                mbet_pkg::CFG_REAL_STEP:   r_cfg.real_step       <= i_cfg_data[62:0];
                mbet_pkg::CFG_IMAG_STEP:   r_cfg.imag_step       <= i_cfg_data[62:0];
                mbet_pkg::CFG_ITER_LIMIT:  r_cfg.iteration_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/mbet_checker.sv -----
// mbet_checker: port-level checks of the escape-time block over time
// bound to mandelbrot_escape_time; depends on mbet_pkg
module mbet_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input mbet_pkg::t_out_beat            o_out_data
);

    // a stalled result beat stays and holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // an escaped count never exceeds the frame maximum reported with it
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_set |->
            o_out_data.frame_max >= o_out_data.escape_count)
        else $error("frame maximum below escaped count");

    // one pixel at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while a pixel is in work");

    // reset leaves the block idle with no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
